### design/mpks_pkg.sv
package mpks_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int RETRY_COUNT = 3;
   localparam int CFG_WIDTH   = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // sequencer phase codes; unused codes behave as idle
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_HOLD  = 3'd1;
   localparam logic [2:0] PH_PRESS = 3'd2;
   localparam logic [2:0] PH_WAIT  = 3'd3;

   // request kinds; anything else is a tick
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_CYCLE = 2'd2;

   // result codes
   localparam logic [1:0] RES_OK      = 2'd0;
   localparam logic [1:0] RES_TIMEOUT = 2'd1;
   localparam logic [1:0] RES_ERROR   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_FIRST_LIMIT  = 2'd0;
   localparam logic [1:0] REG_SECOND_LIMIT = 2'd1;
   localparam logic [1:0] REG_THIRD_LIMIT  = 2'd2;
   localparam logic [1:0] REG_OFF_WAIT     = 2'd3;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] first_limit;
      logic [CFG_WIDTH-1:0] second_limit;
      logic [CFG_WIDTH-1:0] third_limit;
      logic [CFG_WIDTH-1:0] off_wait;
   } mpks_cfg_type;

   typedef struct packed {
      logic [2:0]             phase;
      logic [1:0]             attempt_index;
      logic [COUNT_WIDTH-1:0] tick_count;
      logic                   target_level;
      logic                   cycle_pending_on;
   } mpks_state_type;

   typedef struct packed {
      logic       power_key;
      logic       busy_res;
      logic       done_res;
      logic [1:0] result_code;
      logic [1:0] attempt;
   } mpks_result_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       target_on;
      logic       power_status;
      logic       status_ok;
   } mpks_request_type;

endpackage

### design/mpks_csr.sv
module mpks_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [mpks_pkg::CFG_WIDTH-1:0] csr_data,
   output mpks_pkg::mpks_cfg_type       cfg
);
   import mpks_pkg::*;

   mpks_cfg_type cfg_ff;
   mpks_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FIRST_LIMIT:  cfg_in.first_limit  = csr_data;
            REG_SECOND_LIMIT: cfg_in.second_limit = csr_data;
            REG_THIRD_LIMIT:  cfg_in.third_limit  = csr_data;
            REG_OFF_WAIT:     cfg_in.off_wait     = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_limit  <= CFG_WIDTH'(1000);
         cfg_ff.second_limit <= CFG_WIDTH'(10000);
         cfg_ff.third_limit  <= CFG_WIDTH'(33000);
         cfg_ff.off_wait     <= CFG_WIDTH'(1000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/mpks_step.sv
module mpks_step (
   input  mpks_pkg::mpks_state_type   state,
   input  mpks_pkg::mpks_cfg_type     cfg,
   input  mpks_pkg::mpks_request_type req,
   output mpks_pkg::mpks_state_type   state_next,
   output mpks_pkg::mpks_result_type  result
);
   import mpks_pkg::*;

   typedef struct packed {
      mpks_state_type st;
      logic           done;
      logic [1:0]     code;
   } mpks_outcome_type;

   function automatic mpks_outcome_type finish_seq(mpks_state_type s, logic [1:0] code);
      mpks_outcome_type o;
      o.st                  = s;
      o.st.phase            = PH_IDLE;
      o.st.cycle_pending_on = 1'b0;
      o.done                = 1'b1;
      o.code                = code;
      return o;
   endfunction

   // status reached the target: go wait off in a power cycle, else done
   function automatic mpks_outcome_type matched(mpks_state_type s);
      mpks_outcome_type o;
      o.st   = s;
      o.done = 1'b0;
      o.code = RES_OK;
      if (!s.target_level && s.cycle_pending_on) begin
         o.st.phase      = PH_WAIT;
         o.st.tick_count = '0;
      end else begin
         o = finish_seq(s, RES_OK);
      end
      return o;
   endfunction

   function automatic mpks_outcome_type press_check(mpks_state_type s, logic pin, logic ok);
      mpks_outcome_type o;
      o.st   = s;
      o.done = 1'b0;
      o.code = RES_OK;
      if (!ok) begin
         o = finish_seq(s, RES_ERROR);
      end else if (pin == s.target_level) begin
         o = matched(s);
      end else begin
         o.st.phase      = PH_HOLD;
         o.st.tick_count = '0;
      end
      return o;
   endfunction

   mpks_outcome_type       outc;
   mpks_state_type         s;
   logic [COUNT_WIDTH-1:0] count_sat;
   logic [CFG_WIDTH-1:0]   lim_raw;
   logic [COUNT_WIDTH-1:0] lim;
   logic                   is_tick;
   logic                   active;

   assign is_tick   = (req.kind != KIND_SET) && (req.kind != KIND_CYCLE);
   assign active    = (state.phase == PH_HOLD) || (state.phase == PH_PRESS) ||
                      (state.phase == PH_WAIT);
   assign count_sat = (state.tick_count == COUNT_MAX) ? state.tick_count :
                      state.tick_count + 1'b1;

   always_comb begin
      case (state.attempt_index)
         2'd0:    lim_raw = cfg.first_limit;
         2'd1:    lim_raw = cfg.second_limit;
         default: lim_raw = cfg.third_limit;
      endcase
   end

   // a limit at the counter's top acts as one below it, so the wait ends
   assign lim = (COUNT_WIDTH'(lim_raw) == COUNT_MAX) ? COUNT_MAX - 1'b1 : COUNT_WIDTH'(lim_raw);

   always_comb begin
      s         = state;
      outc.st   = state;
      outc.done = 1'b0;
      outc.code = RES_OK;
      if (!active) begin
         s.phase = PH_IDLE;
         outc.st = s;
         if (req.kind == KIND_SET) begin
            s.target_level     = req.target_on;
            s.cycle_pending_on = 1'b0;
            s.attempt_index    = '0;
            s.tick_count       = '0;
            outc = press_check(s, req.power_status, req.status_ok);
         end else if (req.kind == KIND_CYCLE) begin
            s.attempt_index = '0;
            s.tick_count    = '0;
            if (!req.status_ok) begin
               outc = finish_seq(s, RES_ERROR);
            end else begin
               s.target_level     = 1'b0;
               s.cycle_pending_on = 1'b1;
               s.phase            = req.power_status ? PH_HOLD : PH_WAIT;
               outc.st            = s;
            end
         end
      end else if (is_tick) begin
         if (state.phase == PH_WAIT) begin
            s.tick_count = count_sat;
            if (count_sat >= COUNT_WIDTH'(cfg.off_wait)) begin
               s.target_level     = 1'b1;
               s.cycle_pending_on = 1'b0;
               s.attempt_index    = '0;
               s.tick_count       = '0;
               outc = press_check(s, req.power_status, req.status_ok);
            end else begin
               outc.st = s;
            end
         end else if (state.phase == PH_PRESS) begin
            outc = press_check(s, req.power_status, req.status_ok);
         end else begin
            if (!req.status_ok) begin
               outc = finish_seq(s, RES_ERROR);
            end else if (req.power_status == state.target_level) begin
               outc = matched(s);
            end else begin
               s.tick_count = count_sat;
               if (count_sat > lim) begin
                  if (({1'b0, state.attempt_index} + 3'd1) < 3'(RETRY_COUNT)) begin
                     s.attempt_index = state.attempt_index + 2'd1;
                     s.tick_count    = '0;
                     s.phase         = PH_PRESS;
                     outc.st         = s;
                  end else begin
                     outc = finish_seq(s, RES_TIMEOUT);
                  end
               end else begin
                  outc.st = s;
               end
            end
         end
      end
   end

   assign state_next         = outc.st;
   assign result.power_key   = (outc.st.phase == PH_HOLD);
   assign result.busy_res    = (outc.st.phase != PH_IDLE);
   assign result.done_res    = outc.done;
   assign result.result_code = outc.code;
   assign result.attempt     = outc.st.attempt_index;

endmodule

### design/modem_power_key_sequencer.sv
// Power-key sequencer for a modem.
// Request channel (req_*): one request per tick or command. req_kind picks a
// tick, a set-power command or a power-cycle command; every request carries
// the sampled power-status pin and a flag telling whether that read worked.
// Response channel (rsp_*): exactly one response per request, giving the key
// level, busy, done, result code and the current attempt index.
// Register channel (csr_*): writes the three attempt limits and the off wait;
// it is always ready and must only be used while no request is in flight.
// Latency: the response for a request is valid the cycle after it is taken.
// Throughput: one request per cycle while responses drain; the whole step is
// settled by the small next-state logic between state and response registers.
// Stall: the response register frees up in the same cycle it is taken, so
// req_ready stays high while the receiver keeps up; while rsp_ready is low
// with a response pending, req_ready drops and state holds.
// Reset: the sequencer returns to idle with attempt 0, and the registers go back
// to their power-up values; no response is pending, but the payload is not reset.
module modem_power_key_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic                           req_target_on,
   input  logic                           req_power_status,
   input  logic                           req_status_ok,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_power_key,
   output logic                           rsp_busy_res,
   output logic                           rsp_done_res,
   output logic [1:0]                     rsp_result_code,
   output logic [1:0]                     rsp_attempt,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [mpks_pkg::CFG_WIDTH-1:0] csr_data
);
   import mpks_pkg::*;

   mpks_cfg_type     cfg;
   mpks_request_type req;
   mpks_state_type   state_ff;
   mpks_state_type   state_in;
   mpks_result_type  result_in;
   mpks_result_type  result_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             req_take;

   mpks_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req.kind         = req_kind;
   assign req.target_on    = req_target_on;
   assign req.power_status = req_power_status;
   assign req.status_ok    = req_status_ok;

   mpks_step u_step (
      .state      (state_ff),
      .cfg        (cfg),
      .req        (req),
      .state_next (state_in),
      .result     (result_in)
   );

   // take a new request whenever the response slot is empty or draining
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_take     = req_valid && req_ready;
   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase            <= PH_IDLE;
         state_ff.attempt_index    <= '0;
         state_ff.tick_count       <= '0;
         state_ff.target_level     <= 1'b0;
         state_ff.cycle_pending_on <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         // advance the sequencer only on a taken request
         if (req_take) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload: load on a taken request, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_power_key   = result_ff.power_key;
   assign rsp_busy_res    = result_ff.busy_res;
   assign rsp_done_res    = result_ff.done_res;
   assign rsp_result_code = result_ff.result_code;
   assign rsp_attempt     = result_ff.attempt;

   // a taken request always yields a response next cycle
   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("taken request produced no response");

   // key is only pressed while a sequence runs
   a_key_implies_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_key |-> rsp_busy_res)
      else $error("power key high while not busy");

   // a finished command leaves the sequencer idle, and only it carries a code
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done response while still busy");

   a_code_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_result_code == RES_OK)
      else $error("result code set without done");

   // attempt index stays within the retry budget
   a_attempt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.attempt_index < 2'(RETRY_COUNT))
      else $error("attempt index beyond retry count");

endmodule
